/* sv/lfpd_pkg.sv */
// ----------------------------------------------------------------------------
// lfpd_pkg
// Shared types, constants and register map of the line-follow PD steering block.
// ----------------------------------------------------------------------------
package lfpd_pkg;

  localparam int POS_W       = 13;
  localparam int GAIN_W      = 16;
  localparam int SPEED_W     = 8;
  localparam int ERR_W       = 14;
  localparam int DIFF_W      = 15;
  localparam int ACC_W       = 32;
  localparam int PD_W        = 16;
  localparam int LVL_W       = 17;
  localparam int TURN_CNT_W  = 11;
  localparam int CMD_W       = 2;

  localparam int PADDR_W     = 5;
  localparam int PDATA_W     = 32;

  localparam logic [TURN_CNT_W-1:0] MAX_TURNS = 11'd2000;

  localparam logic [POS_W-1:0] POS_LEFT_EXTREME  = 13'd0;
  localparam logic [POS_W-1:0] POS_RIGHT_EXTREME = 13'd7000;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_FORWARD = 2'd0,
    CMD_LEFT    = 2'd1,
    CMD_RIGHT   = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_GOAL_POSITION = 3'd0,
    REG_PROP_GAIN     = 3'd1,
    REG_DERIV_GAIN    = 3'd2,
    REG_BASE_SPEED    = 3'd3,
    REG_MIN_SPEED     = 3'd4,
    REG_TURN_SPEED    = 3'd5,
    REG_CENTER_LOW    = 3'd6,
    REG_CENTER_HIGH   = 3'd7
  } reg_e;

  typedef enum logic {
    KIND_PD   = 1'b0,
    KIND_TURN = 1'b1
  } kind_e;

  typedef struct packed {
    logic [POS_W-1:0]   goal_position;
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  deriv_gain;
    logic [SPEED_W-1:0] base_speed;
    logic [SPEED_W-1:0] min_speed;
    logic [SPEED_W-1:0] turn_speed;
    logic [POS_W-1:0]   center_low;
    logic [POS_W-1:0]   center_high;
  } cfg_t;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] pos;
    logic             turn_right;
    logic             extreme;
  } entry_t;

  function automatic cmd_e sharp_cmd(input logic right);
    sharp_cmd = right ? CMD_RIGHT : CMD_LEFT;
  endfunction

endpackage

/* sv/lfpd_sample_if.sv */
// ----------------------------------------------------------------------------
// lfpd_sample_if
// Valid/ready channel carrying one line-position sample.
// ----------------------------------------------------------------------------
interface lfpd_sample_if import lfpd_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [POS_W-1:0] line_position;

  modport source (output valid, output line_position, input ready);
  modport sink   (input valid, input line_position, output ready);

endinterface

/* sv/lfpd_cmd_if.sv */
// ----------------------------------------------------------------------------
// lfpd_cmd_if
// Valid/ready channel carrying one drive command.
// ----------------------------------------------------------------------------
interface lfpd_cmd_if import lfpd_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   drive_command;
  logic [SPEED_W-1:0] first_speed;
  logic [SPEED_W-1:0] second_speed;
  logic               last_of_run;

  modport source (output valid, output drive_command, output first_speed,
                  output second_speed, output last_of_run, input ready);
  modport sink   (input valid, input drive_command, input first_speed,
                  input second_speed, input last_of_run, output ready);

endinterface

/* sv/line_follow_pd_steering.sv */
// ----------------------------------------------------------------------------
// line_follow_pd_steering
// PD steering controller for a differential-drive line follower.
//
//   channel    dir  handshake        payload
//   sample_i   in   valid/ready      line_position
//   command_o  out  valid/ready      drive_command, first/second_speed,
//                                    last_of_run
//   apb        in   psel/penable     8 config registers at 4*i
//
// A forward request passes the execution side in order: operand load,
// two passes through the shared multiplier, then clamp and output; an extreme
// sample adds a further state for its sharp-turn command. A recovery turn is
// issued from idle; a dropped sample is not queued. Intake runs ahead via a
// 2-entry queue and stalls only when it is full; the output register holds a
// command until taken. Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module line_follow_pd_steering import lfpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  lfpd_sample_if.sink        sample_i,
  lfpd_cmd_if.source         command_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t   cfg;
  logic   push, space, pop, q_valid;
  entry_t push_entry, head_entry;

  lfpd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (sample_i),
    .push_o   (push),
    .entry_o  (push_entry),
    .space_i  (space)
  );

  lfpd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .space_o (space),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  lfpd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .valid_i   (q_valid),
    .entry_i   (head_entry),
    .pop_o     (pop),
    .command_o (command_o)
  );

endmodule

/* sv/lfpd_regs.sv */
// ----------------------------------------------------------------------------
// lfpd_regs
// APB configuration register file.
// ----------------------------------------------------------------------------
module lfpd_regs import lfpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e idx;
  logic wr_en;

  assign pready = 1'b1;
  assign idx    = reg_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_GOAL_POSITION: cfg_d.goal_position = pwdata[POS_W-1:0];
        REG_PROP_GAIN:     cfg_d.prop_gain     = pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:    cfg_d.deriv_gain    = pwdata[GAIN_W-1:0];
        REG_BASE_SPEED:    cfg_d.base_speed    = pwdata[SPEED_W-1:0];
        REG_MIN_SPEED:     cfg_d.min_speed     = pwdata[SPEED_W-1:0];
        REG_TURN_SPEED:    cfg_d.turn_speed    = pwdata[SPEED_W-1:0];
        REG_CENTER_LOW:    cfg_d.center_low    = pwdata[POS_W-1:0];
        REG_CENTER_HIGH:   cfg_d.center_high   = pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GOAL_POSITION: prdata = PDATA_W'(cfg_q.goal_position);
      REG_PROP_GAIN:     prdata = PDATA_W'(cfg_q.prop_gain);
      REG_DERIV_GAIN:    prdata = PDATA_W'(cfg_q.deriv_gain);
      REG_BASE_SPEED:    prdata = PDATA_W'(cfg_q.base_speed);
      REG_MIN_SPEED:     prdata = PDATA_W'(cfg_q.min_speed);
      REG_TURN_SPEED:    prdata = PDATA_W'(cfg_q.turn_speed);
      REG_CENTER_LOW:    prdata = PDATA_W'(cfg_q.center_low);
      REG_CENTER_HIGH:   prdata = PDATA_W'(cfg_q.center_high);
      default:           prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.goal_position <= 13'd3500;
      cfg_q.prop_gain     <= 16'd1573;
      cfg_q.deriv_gain    <= 16'd6554;
      cfg_q.base_speed    <= 8'd65;
      cfg_q.min_speed     <= 8'd0;
      cfg_q.turn_speed    <= 8'd65;
      cfg_q.center_low    <= 13'd3200;
      cfg_q.center_high   <= 13'd3800;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* sv/lfpd_front.sv */
// ----------------------------------------------------------------------------
// lfpd_front
// Sample intake: tracks recovery mode and classifies each request.
// ----------------------------------------------------------------------------
module lfpd_front import lfpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  lfpd_sample_if.sink        sample_i,
  output logic               push_o,
  output entry_t             entry_o,
  input  logic               space_i
);

  logic                  recov_q, recov_d;
  logic                  right_q, right_d;
  logic [TURN_CNT_W-1:0] turns_q, turns_d;
  logic                  accept;
  logic                  centered;
  logic                  extreme;
  logic                  at_right;
  logic [POS_W-1:0]      pos;

  assign sample_i.ready = space_i;
  assign accept   = sample_i.valid && space_i;
  assign pos      = sample_i.line_position;
  assign at_right = (pos == POS_RIGHT_EXTREME);
  assign extreme  = (pos == POS_LEFT_EXTREME) || at_right;
  assign centered = (pos > cfg_i.center_low) && (pos < cfg_i.center_high);

  always_comb begin
    recov_d = recov_q;
    right_d = right_q;
    turns_d = turns_q;
    push_o  = 1'b0;
    entry_o.kind       = KIND_PD;
    entry_o.pos        = pos;
    entry_o.turn_right = at_right;
    entry_o.extreme    = extreme;
    if (accept) begin
      if (recov_q) begin
        if (centered || (turns_q >= MAX_TURNS)) begin
          recov_d = 1'b0;
          turns_d = '0;
        end else begin
          turns_d            = turns_q + 1'b1;
          push_o             = 1'b1;
          entry_o.kind       = KIND_TURN;
          entry_o.turn_right = right_q;
          entry_o.extreme    = 1'b0;
        end
      end else begin
        push_o = 1'b1;
        if (extreme) begin
          right_d = at_right;
          recov_d = 1'b1;
          turns_d = TURN_CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recov_q <= 1'b0;
      right_q <= 1'b0;
      turns_q <= '0;
    end else begin
      recov_q <= recov_d;
      right_q <= right_d;
      turns_q <= turns_d;
    end
  end

endmodule

/* sv/lfpd_queue.sv */
// ----------------------------------------------------------------------------
// lfpd_queue
// Short FIFO of classified requests between intake and execution.
// ----------------------------------------------------------------------------
module lfpd_queue import lfpd_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   space_o,
  input  logic   pop_i,
  output logic   valid_o,
  output entry_t entry_o
);

  entry_t                mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QUEUE_CW-1:0]   count_q;
  logic                  do_push, do_pop;

  assign space_o = (count_q != QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && space_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [QUEUE_AW-1:0] next_ptr(input logic [QUEUE_AW-1:0] p);
    next_ptr = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

/* sv/lfpd_back.sv */
// ----------------------------------------------------------------------------
// lfpd_back
// Execution: PD arithmetic on a shared multiplier, clamping and command output.
// ----------------------------------------------------------------------------
module lfpd_back import lfpd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               valid_i,
  input  entry_t             entry_i,
  output logic               pop_o,
  lfpd_cmd_if.source         command_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MULP  = 5'b00010,
    ST_MULD  = 5'b00100,
    ST_FIN   = 5'b01000,
    ST_TURN2 = 5'b10000
  } state_e;

  state_e st_q, st_d;

  logic signed [ERR_W-1:0]  prior_q, err_q;
  logic signed [DIFF_W-1:0] diff_q;
  logic signed [ACC_W-1:0]  acc_q, acc_d;
  logic                     ext_q, right_q;
  logic                     load;

  logic signed [ERR_W-1:0]  err_c;
  logic signed [DIFF_W-1:0] diff_c;
  logic signed [GAIN_W:0]   mul_a;
  logic signed [DIFF_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  prod;
  logic signed [ACC_W-1:0]  adj;
  logic signed [PD_W-1:0]   pd;
  logic signed [LVL_W-1:0]  base_s, left_v, right_v;

  logic                     out_valid_q;
  logic [CMD_W-1:0]         out_cmd_q;
  logic [SPEED_W-1:0]       out_a_q, out_b_q;
  logic                     out_last_q;
  logic                     emit_ok, emit;
  cmd_e                     emit_cmd;
  logic [SPEED_W-1:0]       emit_a, emit_b;
  logic                     emit_last;

  function automatic logic [SPEED_W-1:0] clamp_speed(
    input logic signed [LVL_W-1:0] v,
    input logic [SPEED_W-1:0]      lo,
    input logic [SPEED_W-1:0]      hi
  );
    logic signed [LVL_W-1:0] t;
    t = v;
    if (t < $signed({{(LVL_W-SPEED_W){1'b0}}, lo})) t = $signed({{(LVL_W-SPEED_W){1'b0}}, lo});
    if (t > $signed({{(LVL_W-SPEED_W){1'b0}}, hi})) t = $signed({{(LVL_W-SPEED_W){1'b0}}, hi});
    clamp_speed = t[SPEED_W-1:0];
  endfunction

  assign err_c  = $signed({1'b0, cfg_i.goal_position}) - $signed({1'b0, entry_i.pos});
  assign diff_c = $signed({err_c[ERR_W-1], err_c}) - $signed({prior_q[ERR_W-1], prior_q});

  assign mul_a = (st_q == ST_MULP) ? $signed({1'b0, cfg_i.prop_gain})
                                   : $signed({1'b0, cfg_i.deriv_gain});
  assign mul_b = (st_q == ST_MULP) ? $signed({err_q[ERR_W-1], err_q}) : diff_q;
  assign prod  = ACC_W'(mul_a * mul_b);

  assign adj     = acc_q + (acc_q[ACC_W-1] ? $signed(ACC_W'(65535)) : $signed(ACC_W'(0)));
  assign pd      = adj[ACC_W-1 -: PD_W];
  assign base_s  = $signed({{(LVL_W-SPEED_W){1'b0}}, cfg_i.base_speed});
  assign left_v  = base_s - $signed({pd[PD_W-1], pd});
  assign right_v = base_s + $signed({pd[PD_W-1], pd});

  assign emit_ok = !out_valid_q || command_o.ready;

  always_comb begin
    st_d      = st_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    emit      = 1'b0;
    emit_cmd  = CMD_FORWARD;
    emit_a    = cfg_i.base_speed;
    emit_b    = cfg_i.turn_speed;
    emit_last = 1'b1;
    acc_d     = acc_q;
    case (st_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (entry_i.kind == KIND_PD) begin
            pop_o = 1'b1;
            load  = 1'b1;
            st_d  = ST_MULP;
          end else if (emit_ok) begin
            pop_o    = 1'b1;
            emit     = 1'b1;
            emit_cmd = sharp_cmd(entry_i.turn_right);
          end
        end
      end
      ST_MULP: begin
        acc_d = prod;
        st_d  = ST_MULD;
      end
      ST_MULD: begin
        acc_d = acc_q + prod;
        st_d  = ST_FIN;
      end
      ST_FIN: begin
        if (emit_ok) begin
          emit      = 1'b1;
          emit_cmd  = CMD_FORWARD;
          emit_a    = clamp_speed(left_v, cfg_i.min_speed, cfg_i.base_speed);
          emit_b    = clamp_speed(right_v, cfg_i.min_speed, cfg_i.base_speed);
          emit_last = !ext_q;
          st_d      = ext_q ? ST_TURN2 : ST_IDLE;
        end
      end
      ST_TURN2: begin
        if (emit_ok) begin
          emit     = 1'b1;
          emit_cmd = sharp_cmd(right_q);
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (load) begin
      err_q   <= err_c;
      diff_q  <= diff_c;
      ext_q   <= entry_i.extreme;
      right_q <= entry_i.turn_right;
    end
    if (emit) begin
      out_cmd_q  <= emit_cmd;
      out_a_q    <= emit_a;
      out_b_q    <= emit_b;
      out_last_q <= emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      prior_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (load) begin
        prior_q <= err_c;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (command_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign command_o.valid         = out_valid_q;
  assign command_o.drive_command = out_cmd_q;
  assign command_o.first_speed   = out_a_q;
  assign command_o.second_speed  = out_b_q;
  assign command_o.last_of_run   = out_last_q;

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the line-follow PD steering block.
//
// Sends line-position samples through the sample channel and compares every
// drive command with a cycle-free predictor of the PD law, the wheel clamp
// and the sharp-turn recovery. The predictor is updated as each sample is
// accepted, its register copy on each write. Registers are written over the
// config port only while the block is drained. The run covers reset
// settings, a long recovery run with an empty center band, and random
// traffic under three idle patterns with a long receiver stall.
// ----------------------------------------------------------------------------
module tb_top import lfpd_pkg::*; ();

  typedef struct packed {
    cmd_e               cmd;
    logic [SPEED_W-1:0] first_lvl;
    logic [SPEED_W-1:0] second_lvl;
    logic               last_flag;
  } drive_cmd_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lfpd_sample_if sample_ch ();
  lfpd_cmd_if    cmd_ch ();

  line_follow_pd_steering dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .sample_i  (sample_ch),
    .command_o (cmd_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // predictor state and register copy
  cfg_t                   steer_cfg;
  logic signed [ERR_W-1:0] prior_err;
  logic                   recovering;
  logic                   turn_right;
  logic [TURN_CNT_W-1:0]  turns_issued;

  logic [POS_W-1:0] sample_queue[$];
  drive_cmd_t       expected_cmds[$];
  drive_cmd_t       head_cmd;

  int  send_idle_pct;
  int  recv_idle_pct;
  int  mismatches;
  int  samples_sent;
  int  cmds_checked;
  int  sharp_seen;
  bit  hold_go;
  logic rx_hold;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("timeout with %0d commands outstanding", expected_cmds.size());
    $display("FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [SPEED_W-1:0] clamp_level(input longint v);
    longint r;
    r = v;
    if (r < longint'(steer_cfg.min_speed)) r = longint'(steer_cfg.min_speed);
    if (r > longint'(steer_cfg.base_speed)) r = longint'(steer_cfg.base_speed);
    if (r < 0) r = 0;
    return r[SPEED_W-1:0];
  endfunction

  function automatic drive_cmd_t make_cmd(input cmd_e c, input logic [SPEED_W-1:0] a,
                                          input logic [SPEED_W-1:0] b, input logic l);
    drive_cmd_t d;
    d.cmd        = c;
    d.first_lvl  = a;
    d.second_lvl = b;
    d.last_flag  = l;
    return d;
  endfunction

  function automatic void steer_predict(input logic [POS_W-1:0] pos);
    longint err;
    longint diff;
    longint acc;
    longint pd;
    logic   extreme;
    cmd_e   sharp;
    sharp = turn_right ? CMD_RIGHT : CMD_LEFT;
    if (recovering) begin
      if ((pos > steer_cfg.center_low && pos < steer_cfg.center_high) ||
          turns_issued >= MAX_TURNS) begin
        recovering   = 1'b0;
        turns_issued = '0;
      end else begin
        turns_issued = turns_issued + 1'b1;
        expected_cmds.push_back(make_cmd(sharp, steer_cfg.base_speed,
                                         steer_cfg.turn_speed, 1'b1));
        sharp_seen++;
      end
      return;
    end
    err  = longint'(steer_cfg.goal_position) - longint'(pos);
    diff = err - longint'(prior_err);
    acc  = longint'(steer_cfg.prop_gain) * err + longint'(steer_cfg.deriv_gain) * diff;
    if (acc < 0) pd = -((-acc) >>> 16);
    else pd = acc >>> 16;
    prior_err = err[ERR_W-1:0];
    extreme = (pos == POS_LEFT_EXTREME) || (pos == POS_RIGHT_EXTREME);
    expected_cmds.push_back(make_cmd(CMD_FORWARD,
                                     clamp_level(longint'(steer_cfg.base_speed) - pd),
                                     clamp_level(longint'(steer_cfg.base_speed) + pd),
                                     !extreme));
    if (extreme) begin
      turn_right   = (pos == POS_RIGHT_EXTREME);
      recovering   = 1'b1;
      turns_issued = TURN_CNT_W'(1);
      expected_cmds.push_back(make_cmd(turn_right ? CMD_RIGHT : CMD_LEFT,
                                       steer_cfg.base_speed, steer_cfg.turn_speed, 1'b1));
      sharp_seen++;
    end
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sample_ch.valid <= 1'b0;
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        steer_predict(sample_ch.line_position);
        samples_sent++;
      end
      if (!sample_ch.valid || sample_ch.ready) begin
        if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample_ch.valid         <= 1'b1;
          sample_ch.line_position <= sample_queue.pop_front();
        end else begin
          sample_ch.valid <= 1'b0;
        end
      end
    end
  end

  // command monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cmd_ch.ready <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected command", cmd_ch.drive_command, 0);
        end else begin
          head_cmd = expected_cmds.pop_front();
          cmds_checked++;
          if (cmd_ch.drive_command !== head_cmd.cmd)
            report_mismatch("drive_command", cmd_ch.drive_command, head_cmd.cmd);
          if (cmd_ch.first_speed !== head_cmd.first_lvl)
            report_mismatch("first_speed", cmd_ch.first_speed, head_cmd.first_lvl);
          if (cmd_ch.second_speed !== head_cmd.second_lvl)
            report_mismatch("second_speed", cmd_ch.second_speed, head_cmd.second_lvl);
          if (cmd_ch.last_of_run !== head_cmd.last_flag)
            report_mismatch("last_of_run", cmd_ch.last_of_run, head_cmd.last_flag);
        end
      end
      cmd_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver stall, counted here
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  function automatic void apply_setting(input reg_e idx, input logic [PDATA_W-1:0] v);
    case (idx)
      REG_GOAL_POSITION: steer_cfg.goal_position = v[POS_W-1:0];
      REG_PROP_GAIN:     steer_cfg.prop_gain     = v[GAIN_W-1:0];
      REG_DERIV_GAIN:    steer_cfg.deriv_gain    = v[GAIN_W-1:0];
      REG_BASE_SPEED:    steer_cfg.base_speed    = v[SPEED_W-1:0];
      REG_MIN_SPEED:     steer_cfg.min_speed     = v[SPEED_W-1:0];
      REG_TURN_SPEED:    steer_cfg.turn_speed    = v[SPEED_W-1:0];
      REG_CENTER_LOW:    steer_cfg.center_low    = v[POS_W-1:0];
      REG_CENTER_HIGH:   steer_cfg.center_high   = v[POS_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(input reg_e idx, input logic [PDATA_W-1:0] field,
                           input int width);
    logic [PDATA_W-1:0] v;
    v = field;
    // junk above the field on some writes
    if ($urandom_range(1)) v = v | ($urandom() << width);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx) << 2;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    apply_setting(idx, v);
  endtask

  task automatic load_settings(input cfg_t s);
    write_reg(REG_GOAL_POSITION, PDATA_W'(s.goal_position), POS_W);
    write_reg(REG_PROP_GAIN,     PDATA_W'(s.prop_gain),     GAIN_W);
    write_reg(REG_DERIV_GAIN,    PDATA_W'(s.deriv_gain),    GAIN_W);
    write_reg(REG_BASE_SPEED,    PDATA_W'(s.base_speed),    SPEED_W);
    write_reg(REG_MIN_SPEED,     PDATA_W'(s.min_speed),     SPEED_W);
    write_reg(REG_TURN_SPEED,    PDATA_W'(s.turn_speed),    SPEED_W);
    write_reg(REG_CENTER_LOW,    PDATA_W'(s.center_low),    POS_W);
    write_reg(REG_CENTER_HIGH,   PDATA_W'(s.center_high),   POS_W);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (sample_queue.size() != 0 || sample_ch.valid || expected_cmds.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic [POS_W-1:0] any_pos();
    if ($urandom_range(9) == 0) return POS_W'($urandom_range(8191, 7001));
    return POS_W'($urandom_range(7000));
  endfunction

  function automatic logic [POS_W-1:0] off_center();
    if ($urandom_range(1)) return POS_W'($urandom_range(steer_cfg.center_low));
    return POS_W'($urandom_range(8191, steer_cfg.center_high));
  endfunction

  function automatic logic [POS_W-1:0] centered();
    if (steer_cfg.center_high > steer_cfg.center_low + 1)
      return POS_W'($urandom_range(steer_cfg.center_high - 1, steer_cfg.center_low + 1));
    return any_pos();
  endfunction

  task automatic run_traffic(input int count);
    int sent;
    int burst;
    int turns;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(80, 10);
      repeat (burst) begin
        if ($urandom_range(99) < 6) begin
          sample_queue.push_back($urandom_range(1) ? POS_RIGHT_EXTREME : POS_LEFT_EXTREME);
          turns = $urandom_range(6);
          repeat (turns) sample_queue.push_back(off_center());
          sample_queue.push_back(centered());
          sent += turns + 2;
        end else begin
          sample_queue.push_back(any_pos());
          sent++;
        end
      end
      if ($urandom_range(3) == 0) wait_drained();
      else while (sample_queue.size() > 3) @(posedge clk_i);
    end
    wait_drained();
  endtask

  initial begin
    cfg_t s;
    int   lo;
    int   directed_pos [19];
    rst_ni                  = 1'b0;
    psel                    = 1'b0;
    penable                 = 1'b0;
    pwrite                  = 1'b0;
    paddr                   = '0;
    pwdata                  = '0;
    sample_ch.valid         = 1'b0;
    sample_ch.line_position = '0;
    cmd_ch.ready            = 1'b0;
    hold_go                 = 1'b0;
    mismatches              = 0;
    samples_sent            = 0;
    cmds_checked            = 0;
    sharp_seen              = 0;
    steer_cfg.goal_position = 13'd3500;
    steer_cfg.prop_gain     = 16'd1573;
    steer_cfg.deriv_gain    = 16'd6554;
    steer_cfg.base_speed    = 8'd65;
    steer_cfg.min_speed     = 8'd0;
    steer_cfg.turn_speed    = 8'd65;
    steer_cfg.center_low    = 13'd3200;
    steer_cfg.center_high   = 13'd3800;
    prior_err               = '0;
    recovering              = 1'b0;
    turn_right              = 1'b0;
    turns_issued            = '0;
    send_idle_pct           = 23;
    recv_idle_pct           = 64;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: both extremes, band edges, exits, raw max sample
    directed_pos = '{3500, 0, 100, 3200, 3800, 3500, 7000, 3201, 8191, 6999,
                     1, 7000, 0, 3799, 5000, 4096, 2000, 4095, 3500};
    foreach (directed_pos[i])
      sample_queue.push_back(POS_W'(directed_pos[i]));
    wait_drained();

    // empty band: recovery keeps turning
    s.goal_position = 13'd8191;
    s.prop_gain     = 16'd12345;
    s.deriv_gain    = 16'd54321;
    s.base_speed    = 8'd0;
    s.min_speed     = 8'd255;
    s.turn_speed    = 8'hAA;
    s.center_low    = 13'd7000;
    s.center_high   = 13'd0;
    load_settings(s);
    sample_queue.push_back(POS_LEFT_EXTREME);
    repeat (40) sample_queue.push_back(POS_W'($urandom_range(6999, 1)));
    wait_drained();

    s.goal_position = 13'($urandom_range(4500, 2500));
    s.prop_gain     = 16'($urandom());
    s.deriv_gain    = 16'($urandom());
    s.base_speed    = 8'($urandom_range(255, 40));
    s.min_speed     = 8'($urandom_range(40));
    s.turn_speed    = 8'($urandom());
    lo              = $urandom_range(600, 100);
    s.center_low    = s.goal_position - 13'(lo);
    s.center_high   = s.goal_position + 13'($urandom_range(600, 100));
    load_settings(s);
    run_traffic(600);

    send_idle_pct = 64;
    recv_idle_pct = 23;
    s.goal_position = 13'd7000;
    s.prop_gain     = 16'hFFFF;
    s.deriv_gain    = 16'hFFFF;
    s.base_speed    = 8'd255;
    s.min_speed     = 8'd0;
    s.turn_speed    = 8'd255;
    s.center_low    = 13'd0;
    s.center_high   = 13'd7000;
    load_settings(s);
    run_traffic(600);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // min above base: base wins
    s.goal_position = 13'd0;
    s.prop_gain     = 16'd0;
    s.deriv_gain    = 16'hFFFF;
    s.base_speed    = 8'd100;
    s.min_speed     = 8'd200;
    s.turn_speed    = 8'd0;
    s.center_low    = 13'd3000;
    s.center_high   = 13'd3100;
    load_settings(s);
    hold_go = 1'b1;
    repeat (60) sample_queue.push_back(any_pos());
    wait_drained();
    s.goal_position = 13'($urandom_range(7000));
    s.prop_gain     = 16'($urandom());
    s.deriv_gain    = 16'($urandom());
    s.base_speed    = 8'($urandom());
    s.min_speed     = 8'($urandom());
    s.turn_speed    = 8'($urandom());
    s.center_low    = 13'($urandom_range(3500, 1000));
    s.center_high   = 13'($urandom_range(6000, 3600));
    load_settings(s);
    run_traffic(550);

    if (expected_cmds.size() != 0)
      report_mismatch("commands never seen", expected_cmds.size(), 0);
    $display("ran %0d samples, checked %0d commands (%0d sharp turns)",
             samples_sent, cmds_checked, sharp_seen);
    $display("five register settings incl. clamp inversion and an empty-band recovery run");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
